@@ rtl/texp_pkg.sv @@
// Shared types and constants for the Taylor-series e^x block.
// No dependencies; every other file imports this package.
package texp_pkg;

    // Word field widths
    localparam int X_W      = 32;   // exponent, signed Q5.27
    localparam int TC_W     = 6;    // term count field
    localparam int ACC_W    = 64;   // Q32.32 sum and term magnitude
    localparam int FRAC_X   = 27;   // fraction bits of x
    localparam int PROD_W   = ACC_W + X_W;          // magnitude * |x|
    localparam int DIVD_W   = PROD_W - 1 - FRAC_X;  // product >> 27, top bit always 0
    localparam int DIV_BITS = 4;                    // quotient bits per divider cycle
    localparam int DIV_STEPS = DIVD_W / DIV_BITS;

    localparam int MAX_TERMS_DEF = 32;

    localparam logic [ACC_W-1:0] Q32_ONE = 64'h0000_0001_0000_0000;
    localparam logic [ACC_W-1:0] BIAS    = 64'h8000_0000_0000_0000;
    localparam logic [ACC_W-1:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ACCUM,
        ST_DONE
    } texp_state_t;

    // Multiplier status toward the sequencer
    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_res_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [ACC_W-1:0] mag;
    } div_res_t;

endpackage

@@ rtl/texp_if.sv @@
// Valid/ready channel interfaces for the input and result words.
// Depends on texp_pkg for field widths.
interface texp_in_if import texp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [X_W-1:0]  x_value;
    logic [TC_W-1:0]        term_count;

    modport source (output valid, x_value, term_count, input ready);
    modport sink   (input valid, x_value, term_count, output ready);
endinterface

interface texp_out_if import texp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] approximation;
    logic                    invalid_count;
    logic                    saturated;

    modport source (output valid, approximation, invalid_count, saturated, input ready);
    modport sink   (input valid, approximation, invalid_count, saturated, output ready);
endinterface

@@ rtl/texp_mul.sv @@
// Shared 32x32 multiplier: forms the 64x32 product of the term magnitude and |x|
// in two passes plus a final add. Depends on texp_pkg.
module texp_mul import texp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ACC_W-1:0] mag,
    input  logic [X_W-1:0]   xmag,
    output mul_res_t         res
);

    localparam logic [1:0] PH_LO  = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_SUM = 2'd2;

    logic              busy_reg;
    logic [1:0]        ph_reg;
    logic              done_reg;
    logic [X_W-1:0]    op_a;
    logic [2*X_W-1:0]  pp;
    logic [2*X_W-1:0]  p0_reg;
    logic [2*X_W-1:0]  p1_reg;
    logic [PROD_W-1:0] prod_reg;

    // One multiplier, low half first then high half
    assign op_a = (ph_reg == PH_HI) ? mag[ACC_W-1:X_W] : mag[X_W-1:0];
    assign pp   = op_a * xmag;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= PH_LO;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= PH_LO;
            end
            else if (busy_reg)
            begin
                case (ph_reg)
                    PH_LO:   ph_reg <= PH_HI;
                    PH_HI:   ph_reg <= PH_SUM;
                    PH_SUM:
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    default: busy_reg <= 1'b0;
                endcase
            end
        end
    end

    // Partial products and their sum
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            case (ph_reg)
                PH_LO:   p0_reg <= pp;
                PH_HI:   p1_reg <= pp;
                PH_SUM:  prod_reg <= {{X_W{1'b0}}, p0_reg} + {p1_reg, {X_W{1'b0}}};
                default: p0_reg <= p0_reg;
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.prod = prod_reg;

endmodule

@@ rtl/texp_div.sv @@
// Radix-16 divider by the small term index k, with round-to-nearest on the
// full (k * 2^27) divisor and clamping to 63 bits. Depends on texp_pkg.
module texp_div import texp_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [DIVD_W-1:0]                    dividend,
    input  logic [FRAC_X-1:0]                    low_bits,
    input  logic [$clog2(MAX_TERMS+1)-1:0]       divisor,
    output div_res_t                             res
);

    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int DCNT_W = $clog2(DIV_STEPS);
    localparam int RND_W  = CNT_W + FRAC_X + 1;

    logic                busy_reg;
    logic                done_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [DIVD_W-1:0]   work_reg;   // dividend bits shift out, quotient bits shift in
    logic [CNT_W:0]      rem_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [FRAC_X-1:0]   low_reg;

    logic [CNT_W:0]      rem_next;
    logic [DIV_BITS-1:0] qdig;
    logic [RND_W-1:0]    twice_rem;
    logic [RND_W-1:0]    full_den;
    logic                round_up;
    logic [DIVD_W:0]     q_rnd;

    // Four restoring steps per cycle on the narrow remainder
    always_comb
    begin
        rem_next = rem_reg;
        qdig     = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            rem_next = {rem_next[CNT_W-1:0], work_reg[DIVD_W-1-i]};
            if (rem_next >= {1'b0, k_reg})
            begin
                rem_next = rem_next - {1'b0, k_reg};
                qdig[DIV_BITS-1-i] = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            k_reg    <= divisor;
            low_reg  <= low_bits;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[DIVD_W-DIV_BITS-1:0], qdig};
            rem_reg  <= rem_next;
        end
    end

    // Rounding: full remainder is rem * 2^27 + low bits; round up when 2r >= k * 2^27
    assign twice_rem = {rem_reg[CNT_W-1:0], low_reg, 1'b0};
    assign full_den  = {1'b0, k_reg, {FRAC_X{1'b0}}};
    assign round_up  = (twice_rem >= full_den);
    assign q_rnd     = {1'b0, work_reg} + {{DIVD_W{1'b0}}, round_up};

    assign res.done = done_reg;
    assign res.ovf  = (q_rnd > (DIVD_W+1)'(MAG_MAX));
    assign res.mag  = res.ovf ? MAG_MAX : q_rnd[ACC_W-1:0];

endmodule

@@ rtl/taylor_exp_approximator_top.sv @@
// Each term after the first runs through a multiplier pass (start, then wait), a
// divider pass (start, then wait) and one add; a zero or one-term count skips these
// steps. One word at a time; the next input is taken once the current one reaches
// the output register.
// Reset (rst_n, async, active low) clears the sequencer and the output valid.
// Depends on texp_pkg, texp_if, texp_mul and texp_div.
module taylor_exp_approximator_top import texp_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    texp_in_if.sink       din,
    texp_out_if.source    dout
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int CMP_W = (CNT_W > TC_W) ? CNT_W : TC_W;

    texp_state_t      state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [ACC_W-1:0] mag_reg, mag_next;
    logic [ACC_W-1:0] acc_reg, acc_next;   // biased: signed value XOR sign bit
    logic [X_W-1:0]   xmag_reg, xmag_next;
    logic             xneg_reg, xneg_next;
    logic             tneg_reg, tneg_next;
    logic             sat_reg, sat_next;
    logic             inv_reg, inv_next;

    logic             out_valid_reg;
    logic [ACC_W-1:0] out_approx_reg;
    logic             out_inv_reg;
    logic             out_sat_reg;

    logic             accept;
    logic             out_load;
    logic             mul_start;
    logic             div_start;
    mul_res_t         mul_res;
    div_res_t         div_res;

    logic [CMP_W-1:0] tc_ext;
    logic [CNT_W-1:0] n_clamped;
    logic [CNT_W-1:0] k_inc;
    logic [ACC_W:0]   add_sum;

    assign accept   = din.valid && din.ready;
    assign din.ready = (state_reg == ST_IDLE);

    assign tc_ext    = CMP_W'(din.term_count);
    assign n_clamped = (tc_ext > CMP_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(tc_ext);
    assign k_inc     = k_reg + 1'b1;
    assign add_sum   = {1'b0, acc_reg} + {1'b0, mag_reg};

    texp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .mag   (mag_reg),
        .xmag  (xmag_reg),
        .res   (mul_res)
    );

    texp_div #(
        .MAX_TERMS (MAX_TERMS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_res.prod[PROD_W-2:FRAC_X]),
        .low_bits (mul_res.prod[FRAC_X-1:0]),
        .divisor  (k_reg),
        .res      (div_res)
    );

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        mag_next   = mag_reg;
        acc_next   = acc_reg;
        xmag_next  = xmag_reg;
        xneg_next  = xneg_reg;
        tneg_next  = tneg_reg;
        sat_next   = sat_reg;
        inv_next   = inv_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    xneg_next = din.x_value[X_W-1];
                    xmag_next = din.x_value[X_W-1] ? (~din.x_value + 1'b1) : din.x_value;
                    n_next    = n_clamped;
                    k_next    = CNT_W'(1);
                    mag_next  = Q32_ONE;
                    tneg_next = 1'b0;
                    sat_next  = 1'b0;
                    if (din.term_count == '0)
                    begin
                        // Zero count: result 0, flagged invalid
                        inv_next   = 1'b1;
                        acc_next   = BIAS;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        inv_next   = 1'b0;
                        acc_next   = Q32_ONE ^ BIAS;
                        state_next = (n_clamped > CNT_W'(1)) ? ST_MUL_GO : ST_DONE;
                    end
                end
            end
            ST_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (mul_res.done)
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_res.done)
                begin
                    mag_next   = div_res.mag;
                    sat_next   = sat_reg | div_res.ovf;
                    tneg_next  = tneg_reg ^ xneg_reg;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                // Saturating add of the signed term to the biased sum
                if (tneg_reg)
                begin
                    if (mag_reg > acc_reg)
                    begin
                        acc_next = '0;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_reg - mag_reg;
                    end
                end
                else if (add_sum[ACC_W])
                begin
                    acc_next = '1;
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = add_sum[ACC_W-1:0];
                end
                k_next     = k_inc;
                state_next = (k_inc < n_reg) ? ST_MUL_GO : ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        k_reg    <= k_next;
        mag_reg  <= mag_next;
        acc_reg  <= acc_next;
        xmag_reg <= xmag_next;
        xneg_reg <= xneg_next;
        tneg_reg <= tneg_next;
        sat_reg  <= sat_next;
        inv_reg  <= inv_next;
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_approx_reg <= acc_reg ^ BIAS;
            out_inv_reg    <= inv_reg;
            out_sat_reg    <= sat_reg;
        end
    end

    assign dout.valid         = out_valid_reg;
    assign dout.approximation = out_approx_reg;
    assign dout.invalid_count = out_inv_reg;
    assign dout.saturated     = out_sat_reg;

endmodule

@@ dv/tb_taylor_exp_approximator_top.sv @@
// Testbench for taylor_exp_approximator_top: directed table, then random words checked
// against a bit-accurate Taylor-sum predictor. Depends on texp_pkg, texp_if and the RTL.
`timescale 1ns / 1ps

module tb_taylor_exp_approximator_top;
    import texp_pkg::*;

    // Expected result word
    typedef struct packed {
        logic signed [ACC_W-1:0] approximation;
        logic                    invalid_count;
        logic                    saturated;
    } exp_word_t;

    // Directed stimulus row; want is used only when typed is set
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic [TC_W-1:0]       n;
        logic                  typed;
        exp_word_t             want;
    } dir_row_t;

    localparam int DIR_N        = 25;
    localparam int RAND_WORDS   = 1200;
    localparam int TAIL_CYCLES  = 900;

    // Handy Q5.27 values
    localparam logic signed [X_W-1:0] X_ONE  = 32'sh0800_0000;
    localparam logic signed [X_W-1:0] X_MONE = 32'shF800_0000;
    localparam logic signed [X_W-1:0] X_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [X_W-1:0] X_MIN  = 32'sh8000_0000;

    logic clk = 1'b0;
    logic rst_n;

    texp_in_if  din_if();
    texp_out_if dout_if();

    taylor_exp_approximator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    exp_word_t pending_sums [$];
    int        errors = 0;
    int        burst_left = 0;

    dir_row_t dir_rows [DIR_N] = '{
        // zero count: invalid, result 0
        '{32'sh0000_0000, 6'd0,  1'b1, '{64'sh0, 1'b1, 1'b0}},
        '{X_MAX,          6'd0,  1'b1, '{64'sh0, 1'b1, 1'b0}},
        '{X_MIN,          6'd0,  1'b1, '{64'sh0, 1'b1, 1'b0}},
        // single term is just 1.0
        '{32'sh0000_0000, 6'd1,  1'b1, '{Q32_ONE, 1'b0, 1'b0}},
        '{X_MIN,          6'd1,  1'b1, '{Q32_ONE, 1'b0, 1'b0}},
        '{X_MAX,          6'd1,  1'b1, '{Q32_ONE, 1'b0, 1'b0}},
        // x = 0: every later term vanishes; 63 is clamped to the term limit
        '{32'sh0000_0000, 6'd32, 1'b1, '{Q32_ONE, 1'b0, 1'b0}},
        '{32'sh0000_0000, 6'd63, 1'b1, '{Q32_ONE, 1'b0, 1'b0}},
        // two terms: 1 + x
        '{X_ONE,          6'd2,  1'b1, '{64'sh2_0000_0000, 1'b0, 1'b0}},
        '{X_MONE,         6'd2,  1'b1, '{64'sh0, 1'b0, 1'b0}},
        '{32'sh1000_0000, 6'd2,  1'b1, '{64'sh3_0000_0000, 1'b0, 1'b0}},
        // predictor-checked rows
        '{X_MAX,          6'd32, 1'b0, '0},
        '{X_MIN,          6'd32, 1'b0, '0},
        '{X_MIN,          6'd63, 1'b0, '0},
        '{X_MAX,          6'd33, 1'b0, '0},
        '{X_ONE,          6'd32, 1'b0, '0},
        '{X_MONE,         6'd32, 1'b0, '0},
        '{32'sh0000_0001, 6'd5,  1'b0, '0},
        '{32'shFFFF_FFFF, 6'd5,  1'b0, '0},
        '{32'sh0400_0000, 6'd20, 1'b0, '0},
        '{32'shFC00_0000, 6'd20, 1'b0, '0},
        '{32'sh1C00_0000, 6'd16, 1'b0, '0},
        '{32'sh5555_5555, 6'd42, 1'b0, '0},
        '{32'shAAAA_AAAA, 6'd21, 1'b0, '0},
        '{X_MAX,          6'd2,  1'b0, '0}
    };

    // Truncated Taylor sum of e^x: sign/magnitude terms, biased Q32.32 accumulator
    function automatic exp_word_t taylor_sum(logic signed [X_W-1:0] x, logic [TC_W-1:0] n);
        exp_word_t         w;
        logic [X_W-1:0]    xmag;
        logic              xneg;
        logic              tneg;
        logic              sat;
        logic [ACC_W-1:0]  mag;
        logic [ACC_W-1:0]  acc;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] den;
        logic [PROD_W-1:0] quo;
        logic [PROD_W-1:0] rem;
        int                nterms;
        w = '0;
        if (n == '0)
        begin
            w.invalid_count = 1'b1;
            return w;
        end
        nterms = (int'(n) > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(n);
        xneg = x[X_W-1];
        xmag = xneg ? (~x + 1'b1) : x;
        mag  = Q32_ONE;
        tneg = 1'b0;
        sat  = 1'b0;
        acc  = Q32_ONE ^ BIAS;
        for (int k = 1; k < nterms; k++)
        begin
            prod = PROD_W'(mag) * PROD_W'(xmag);
            den  = PROD_W'(k) << FRAC_X;
            quo  = prod / den;
            rem  = prod % den;
            // round to nearest, half away from zero
            if (rem >= den - rem)
                quo = quo + 1'b1;
            if (quo > PROD_W'(MAG_MAX))
            begin
                mag = MAG_MAX;
                sat = 1'b1;
            end
            else
                mag = quo[ACC_W-1:0];
            tneg = tneg ^ xneg;
            // clamp the biased sum at both ends
            if (tneg)
            begin
                if (mag > acc)
                begin
                    acc = '0;
                    sat = 1'b1;
                end
                else
                    acc = acc - mag;
            end
            else
            begin
                if (mag > ~acc)
                begin
                    acc = '1;
                    sat = 1'b1;
                end
                else
                    acc = acc + mag;
            end
        end
        w.approximation = acc ^ BIAS;
        w.saturated     = sat;
        return w;
    endfunction

    // Offer one word in bursts with random gaps; called and left at a falling edge
    task automatic send_word(input logic signed [X_W-1:0] x, input logic [TC_W-1:0] n,
                             input logic typed, input exp_word_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                din_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        din_if.valid      <= 1'b1;
        din_if.x_value    <= x;
        din_if.term_count <= n;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        pending_sums.push_back(typed ? want : taylor_sum(x, n));
        @(negedge clk);
    endtask

    // Hold off until every expected word is back; called at a falling edge
    task automatic drain_sums();
        din_if.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        @(negedge clk);
        burst_left = 0;
    endtask

    // Stimulus
    initial
    begin
        logic signed [X_W-1:0] x;
        logic [TC_W-1:0]       n;
        int unsigned           sel;
        rst_n             = 1'b0;
        din_if.valid      = 1'b0;
        din_if.x_value    = '0;
        din_if.term_count = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_word(dir_rows[i].x, dir_rows[i].n, dir_rows[i].typed, dir_rows[i].want);
        drain_sums();

        for (int i = 0; i < RAND_WORDS; i++)
        begin
            // exponent: full range, small, near +/-1.0, or an extreme
            sel = $urandom_range(0, 99);
            if (sel < 40)
                x = $urandom;
            else if (sel < 70)
                x = $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
            else if (sel < 85)
                x = ($urandom_range(0, 1) ? X_ONE : X_MONE)
                    + $signed($urandom_range(0, 2048)) - 32'sd1024;
            else
            begin
                case ($urandom_range(0, 4))
                    0: x = X_MAX;
                    1: x = X_MIN;
                    2: x = 32'sh0000_0000;
                    3: x = 32'sh0000_0001;
                    default: x = 32'shFFFF_FFFF;
                endcase
            end
            // term count: mostly short series, a few zero, long or clamped
            sel = $urandom_range(0, 99);
            if (sel < 3)
                n = '0;
            else if (sel < 77)
                n = TC_W'($urandom_range(1, 10));
            else if (sel < 93)
                n = TC_W'($urandom_range(11, 32));
            else
                n = TC_W'($urandom_range(33, 63));
            send_word(x, n, 1'b0, '0);
            if (i % 300 == 299)
                drain_sums();
        end
        drain_sums();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result backpressure: the ready pattern switches between four random modes
    int unsigned ready_mode = 0;
    int unsigned mode_left  = 0;
    int unsigned ready_cnt  = 0;

    initial dout_if.ready = 1'b0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        ready_cnt++;
        case (ready_mode)
            0: dout_if.ready <= 1'b1;
            1: dout_if.ready <= ($urandom_range(0, 3) != 0);
            2: dout_if.ready <= ((ready_cnt % 5) < 3);
            default: dout_if.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Result checker
    always @(posedge clk)
    begin : check_words
        exp_word_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("unexpected result word: approximation %h", dout_if.approximation);
                errors++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (dout_if.approximation !== want.approximation)
                begin
                    $error("approximation: expected %h, got %h",
                           want.approximation, dout_if.approximation);
                    errors++;
                end
                if (dout_if.invalid_count !== want.invalid_count)
                begin
                    $error("invalid_count: expected %b, got %b",
                           want.invalid_count, dout_if.invalid_count);
                    errors++;
                end
                if (dout_if.saturated !== want.saturated)
                begin
                    $error("saturated: expected %b, got %b",
                           want.saturated, dout_if.saturated);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #(50_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/texp_pkg.sv
rtl/texp_if.sv
rtl/texp_mul.sv
rtl/texp_div.sv
rtl/taylor_exp_approximator_top.sv
dv/tb_taylor_exp_approximator_top.sv
